### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_PROP_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the usual clk_i and rst_ni of the enclosing module.
`define ASSERT_PROP(label, prop, msg) \
  `ASSERT_PROP_RST(label, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/smsc_pkg.sv
// Package: types and constants of the memory speed table scanner.
package smsc_pkg;

  // Number of bytes of table header skipped before the first structure.
  localparam int unsigned HEADER_SKIP = 8;
  localparam int unsigned HDR_CNT_W   = 4;
  localparam logic [HDR_CNT_W-1:0] HEADER_SKIP_CNT = HDR_CNT_W'(HEADER_SKIP);

  // Structure types and field offsets of interest.
  localparam logic [7:0]  TYPE_MEMORY_DEVICE = 8'd17;
  localparam logic [7:0]  TYPE_END_OF_TABLE  = 8'd127;
  localparam logic [7:0]  SPEED_LO_OFFSET    = 8'h15;
  localparam logic [7:0]  SPEED_HI_OFFSET    = 8'h16;
  localparam logic [7:0]  MIN_STRUCT_LENGTH  = 8'd4;
  localparam logic [15:0] SPEED_UNKNOWN      = 16'hFFFF;

  // Parse phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_TYPE      = 6'b000010,
    PH_LENGTH    = 6'b000100,
    PH_FORMATTED = 6'b001000,
    PH_STRINGS   = 6'b010000,
    PH_STOPPED   = 6'b100000
  } smsc_phase_e;

  localparam smsc_phase_e PH_RESET = (HEADER_SKIP == 0) ? PH_TYPE : PH_HEADER;

  // One table byte as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } smsc_item_t;

endpackage

### rtl/core/smbios_memory_speed_scan_top.sv
// Top level of the memory speed table scanner.
//
//   Channel  Direction  Signals                              Transaction
//   input    in         in_valid_i, in_ready_o               one table byte and its last flag
//   output   out        out_valid_o, out_ready_i             maximum speed of one whole table
//
// One byte is taken per cycle and the parse state advances by one byte per cycle while no last
// byte waits on a busy result register. A byte is parsed at the edge at which it leaves the input
// register; a last byte loads the result register at that same edge.
// Reset clears the parse state and the valid flags of both registers; no clearing pass is needed.
// A waiting result stalls only a last byte; other bytes keep flowing beneath it.
module smbios_memory_speed_scan_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] max_speed_mhz_o
);
  import smsc_pkg::*;

  smsc_item_t in_item;
  smsc_item_t held_item;
  logic       held_valid;
  logic       advance;
  logic       out_free;
  logic [15:0] best_next;

  assign in_item.data = data_byte_i;
  assign in_item.last = last_byte_i;

  // A held byte moves on unless it ends a table and the result register is busy.
  assign advance = held_valid && (!held_item.last || out_free);

  smsc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .advance_i    (advance),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  smsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (held_item),
    .best_next_o (best_next)
  );

  smsc_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance && held_item.last),
    .speed_i         (best_next),
    .free_o          (out_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .max_speed_mhz_o (max_speed_mhz_o)
  );

endmodule

### rtl/core/smsc_in_stage.sv
// Input register: holds one table byte until the parser takes it.
module smsc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smsc_pkg::smsc_item_t item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output smsc_pkg::smsc_item_t item_o
);
  import smsc_pkg::*;

  logic       valid_q, valid_d;
  smsc_item_t item_q;
  logic       accept;

  // The register is free when empty or when its byte moves on this cycle.
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/core/smsc_parser.sv
// Structure walker: updates the parse state by one byte and tracks the best speed.
module smsc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  smsc_pkg::smsc_item_t item_i,
  output logic [15:0]       best_next_o
);
  import smsc_pkg::*;

  smsc_phase_e          phase_q, phase_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [7:0]           offset_q, offset_d;
  logic [7:0]           type_q, type_d;
  logic [7:0]           length_q, length_d;
  logic [15:0]          cand_q, cand_d;
  logic                 prev_zero_q, prev_zero_d;
  logic [15:0]          best_q, best_d;
  logic [7:0]           b;

  assign b = item_i.data;

  // Next state for one consumed byte.
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    offset_d    = offset_q;
    type_d      = type_q;
    length_d    = length_q;
    cand_d      = cand_q;
    prev_zero_d = prev_zero_q;
    best_d      = best_q;
    unique case (phase_q)
      PH_HEADER: begin
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
        if (hdr_cnt_d >= HEADER_SKIP_CNT) begin
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d   = b;
        cand_d   = 16'd0;
        offset_d = 8'd1;
        phase_d  = PH_LENGTH;
      end
      PH_LENGTH: begin
        length_d = b;
        if (b < MIN_STRUCT_LENGTH) begin
          phase_d = PH_STOPPED;
        end else begin
          offset_d = 8'd2;
          phase_d  = PH_FORMATTED;
        end
      end
      PH_FORMATTED: begin
        if (offset_q == SPEED_LO_OFFSET) begin
          cand_d = {cand_q[15:8], b};
        end else if (offset_q == SPEED_HI_OFFSET) begin
          cand_d = {b, cand_q[7:0]};
        end
        offset_d = offset_q + 8'd1;
        if (offset_d == length_q) begin
          // A completed memory-device speed counts when known and larger.
          if ((type_q == TYPE_MEMORY_DEVICE) && (length_q > SPEED_HI_OFFSET) &&
              (cand_d != 16'd0) && (cand_d != SPEED_UNKNOWN) && (cand_d > best_q)) begin
            best_d = cand_d;
          end
          prev_zero_d = 1'b0;
          phase_d     = PH_STRINGS;
        end
      end
      PH_STRINGS: begin
        if (b == 8'd0) begin
          if (prev_zero_q) begin
            prev_zero_d = 1'b0;
            phase_d     = (type_q == TYPE_END_OF_TABLE) ? PH_STOPPED : PH_TYPE;
          end else begin
            prev_zero_d = 1'b1;
          end
        end else begin
          prev_zero_d = 1'b0;
        end
      end
      PH_STOPPED: begin
        phase_d = PH_STOPPED;
      end
      default: begin
        phase_d = PH_RESET;
      end
    endcase
  end

  // State register; the last byte of a table returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RESET;
      hdr_cnt_q   <= '0;
      offset_q    <= '0;
      type_q      <= '0;
      length_q    <= '0;
      cand_q      <= '0;
      prev_zero_q <= 1'b0;
      best_q      <= '0;
    end else if (step_i) begin
      if (item_i.last) begin
        phase_q     <= PH_RESET;
        hdr_cnt_q   <= '0;
        offset_q    <= '0;
        type_q      <= '0;
        length_q    <= '0;
        cand_q      <= '0;
        prev_zero_q <= 1'b0;
        best_q      <= '0;
      end else begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        offset_q    <= offset_d;
        type_q      <= type_d;
        length_q    <= length_d;
        cand_q      <= cand_d;
        prev_zero_q <= prev_zero_d;
        best_q      <= best_d;
      end
    end
  end

  assign best_next_o = best_d;

endmodule

### rtl/core/smsc_out_stage.sv
// Result register: holds the reported maximum speed until it is taken.
module smsc_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [15:0] speed_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] max_speed_mhz_o
);
  logic        valid_q, valid_d;
  logic [15:0] speed_q;

  // The register can take a new result when empty or being emptied.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      speed_q <= speed_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign max_speed_mhz_o = speed_q;

endmodule

### rtl/core/smsc_checker.sv
// Port-level checker of the scanner top level, with its bind.
`include "assert_macros.svh"

module smsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] max_speed_mhz_o
);
  import smsc_pkg::*;

  // An unknown speed is never the reported maximum.
  property p_no_unknown_speed;
    out_valid_o |-> (max_speed_mhz_o != SPEED_UNKNOWN);
  endproperty

  // With room for a result the input side never stalls.
  property p_ready_when_out_free;
    (!out_valid_o || out_ready_i) |-> in_ready_o;
  endproperty

  // A result only appears just after the input register could move.
  property p_result_after_advance;
    $rose(out_valid_o) |-> $past(in_ready_o);
  endproperty

  // A stalled result keeps its value.
  property p_result_held;
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(max_speed_mhz_o));
  endproperty

  `ASSERT_PROP(a_no_unknown_speed, p_no_unknown_speed, "reported speed is the unknown code")
  `ASSERT_PROP(a_ready_when_out_free, p_ready_when_out_free, "input stalled, output free")
  `ASSERT_PROP(a_result_after_advance, p_result_after_advance, "result without a parse step")
  `ASSERT_PROP(a_result_held, p_result_held, "stalled result changed")

endmodule

bind smbios_memory_speed_scan_top smsc_checker u_smsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .max_speed_mhz_o (max_speed_mhz_o)
);
